@@ rtl/date_validate_and_day_difference_top_defines.svh @@
// assertion macros shared by the date check block
`ifndef DATE_VALIDATE_AND_DAY_DIFFERENCE_TOP_DEFINES_SVH
`define DATE_VALIDATE_AND_DAY_DIFFERENCE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DVDD_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dvdd assertion failed");
// next-cycle implication
`define DVDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvdd assertion failed");
`else
`define DVDD_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define DVDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/dvdd_pkg.sv @@
`default_nettype none

package dvdd_pkg;

    localparam logic [7:0] DASH_CHAR = 8'h2D;
    localparam logic [7:0] ZERO_CHAR = 8'h30;
    localparam logic [7:0] NINE_CHAR = 8'h39;

    localparam int unsigned IN_W  = 160;
    localparam int unsigned OUT_W = 32;
    localparam int unsigned DIFF_W = 23;
    localparam int unsigned COUNT_W = 22;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // one decoded date, split along century and year-in-century
    typedef struct packed {
        logic       ok;
        logic       leap;
        logic [4:0] day;
        logic [3:0] mon;
        logic [6:0] cent;
        logic [6:0] yy;
    } t_date;

    typedef struct packed {
        t_date second;
        t_date first;
    } t_pair;

    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/dvdd_front.sv @@
`default_nettype none

module dvdd_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [dvdd_pkg::IN_W-1:0]     i_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output dvdd_pkg::t_pair                    o_pair
);

    function automatic dvdd_pkg::t_date decode(input logic [39:0] head,
                                               input logic [39:0] tail);
        logic [7:0]       ch [10];
        logic [3:0]       dg [10];
        logic             fmt_ok;
        logic [6:0]       day;
        logic [6:0]       mon;
        logic [4:0]       lim;
        dvdd_pkg::t_date  r;
        for (int i = 0; i < 5; i++) begin
            ch[i]     = head[39-8*i -: 8];
            ch[i + 5] = tail[39-8*i -: 8];
        end
        fmt_ok = (ch[2] == dvdd_pkg::DASH_CHAR) && (ch[5] == dvdd_pkg::DASH_CHAR);
        for (int i = 0; i < 10; i++) begin
            dg[i] = ch[i][3:0];
            if (i != 2 && i != 5 &&
                (ch[i] < dvdd_pkg::ZERO_CHAR || ch[i] > dvdd_pkg::NINE_CHAR)) begin
                fmt_ok = 1'b0;
            end
        end
        day    = 7'(dg[0]) * 7'd10 + 7'(dg[1]);
        mon    = 7'(dg[3]) * 7'd10 + 7'(dg[4]);
        r.cent = 7'(dg[6]) * 7'd10 + 7'(dg[7]);
        r.yy   = 7'(dg[8]) * 7'd10 + 7'(dg[9]);
        // century years are leap only when the century divides by four
        r.leap = (r.yy == 7'd0) ? (r.cent[1:0] == 2'd0) : (r.yy[1:0] == 2'd0);
        lim = dvdd_pkg::month_len(mon[3:0]);
        if (mon == 7'(dvdd_pkg::MONTH_FEB) && r.leap) begin
            lim = 5'd29;
        end
        r.day = day[4:0];
        r.mon = mon[3:0];
        r.ok  = fmt_ok
             && (mon >= 7'd1) && (mon <= 7'(dvdd_pkg::MONTH_DEC))
             && (day != 7'd0) && (day <= 7'(lim))
             && ((r.cent != 7'd0) || (r.yy != 7'd0));
        return r;
    endfunction

    logic            r_valid;
    dvdd_pkg::t_pair r_pair;
    dvdd_pkg::t_pair n_pair;

    always_comb begin
        n_pair.first  = decode(i_data[39:0],   i_data[79:40]);
        n_pair.second = decode(i_data[119:80], i_data[159:120]);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pair  = r_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pair <= n_pair;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dvdd_fifo.sv @@
`default_nettype none

module dvdd_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire dvdd_pkg::t_pair i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output dvdd_pkg::t_pair      o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dvdd_pkg::t_pair  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dvdd_back.sv @@
`default_nettype none

module dvdd_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire dvdd_pkg::t_pair            i_pair,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [dvdd_pkg::OUT_W-1:0]      o_data
);

    // year terms ready for the final sum
    typedef struct packed {
        logic        ok;
        logic [13:0] py;
        logic [6:0]  q100;
        logic [4:0]  q400;
        logic [8:0]  part;
    } t_terms;

    function automatic t_terms prep(input dvdd_pkg::t_date d);
        logic [13:0] yr;
        logic        y400;
        t_terms      t;
        yr     = 14'(d.cent) * 14'd100 + 14'(d.yy);
        y400   = (d.yy == 7'd0) && (d.cent[1:0] == 2'd0);
        t.ok   = d.ok;
        t.py   = yr - 14'd1;
        t.q100 = (d.yy != 7'd0) ? d.cent : d.cent - 7'd1;
        t.q400 = d.cent[6:2] - (y400 ? 5'd1 : 5'd0);
        t.part = dvdd_pkg::days_before(d.mon) + 9'(d.day)
               + (((d.mon > dvdd_pkg::MONTH_FEB) && d.leap) ? 9'd1 : 9'd0);
        return t;
    endfunction

    function automatic logic [dvdd_pkg::COUNT_W-1:0] day_count(input t_terms t);
        return dvdd_pkg::COUNT_W'(t.py) * dvdd_pkg::COUNT_W'(365)
             + dvdd_pkg::COUNT_W'(t.py[13:2])
             - dvdd_pkg::COUNT_W'(t.q100)
             + dvdd_pkg::COUNT_W'(t.q400)
             + dvdd_pkg::COUNT_W'(t.part);
    endfunction

    logic                            r_s1_valid;
    t_terms                          r_s1_first;
    t_terms                          r_s1_second;
    logic                            r_s2_valid;
    logic                            r_s2_ok1;
    logic                            r_s2_ok2;
    logic [dvdd_pkg::COUNT_W-1:0]    r_s2_cnt1;
    logic [dvdd_pkg::COUNT_W-1:0]    r_s2_cnt2;
    logic                            r_s3_valid;
    logic [dvdd_pkg::OUT_W-1:0]      r_s3_data;
    logic [dvdd_pkg::DIFF_W-1:0]     n_diff;
    logic                            en1;
    logic                            en2;
    logic                            en3;

    assign en3     = !r_s3_valid || i_ready;
    assign en2     = !r_s2_valid || en3;
    assign en1     = !r_s1_valid || en2;
    assign o_ready = en1;
    assign o_valid = r_s3_valid;
    assign o_data  = r_s3_data;

    always_comb begin
        n_diff = '0;
        if (r_s2_ok1 && r_s2_ok2) begin
            n_diff = {1'b0, r_s2_cnt2} - {1'b0, r_s2_cnt1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (en1) r_s1_valid <= i_valid;
            if (en2) r_s2_valid <= r_s1_valid;
            if (en3) r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_s1_first  <= prep(i_pair.first);
            r_s1_second <= prep(i_pair.second);
        end
        if (en2 && r_s1_valid) begin
            r_s2_ok1  <= r_s1_first.ok;
            r_s2_ok2  <= r_s1_second.ok;
            r_s2_cnt1 <= day_count(r_s1_first);
            r_s2_cnt2 <= day_count(r_s1_second);
        end
        if (en3 && r_s2_valid) begin
            r_s3_data <= {(dvdd_pkg::OUT_W - dvdd_pkg::DIFF_W - 2)'(0),
                          n_diff, r_s2_ok2, r_s2_ok1};
        end
    end

endmodule

`default_nettype wire

@@ rtl/date_validate_and_day_difference_top.sv @@
// date pair check and day difference, DD-MM-YYYY ascii in, signed day count delta out
// a result passes the front register, the queue and the back stage registers before it reaches the master side
// throughput: one item per cycle while the master side is ready, set by the fully pipelined decode and count stages
// the queue between decode and count absorbs up to QUEUE_DEPTH items while the output stalls
// reset: synchronous, active low; clears all valid flags and queue pointers and count, no data cleared
`default_nettype none
`include "date_validate_and_day_difference_top_defines.svh"

module date_validate_and_day_difference_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // slave side
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [39:0] first_head, [79:40] first_tail, [119:80] second_head, [159:120] second_tail
    input  wire logic [159:0]  s_axis_tdata,
    // master side
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [0] first_ok, [1] second_ok, [24:2] day_difference (signed), [31:25] zero
    output logic [31:0]        m_axis_tdata
);

    // decoded pair from the front register into the queue
    logic            front_valid;
    logic            front_ready;
    dvdd_pkg::t_pair front_pair;

    // queue head into the count pipeline
    logic            queue_valid;
    logic            back_ready;
    dvdd_pkg::t_pair queue_pair;

    // front: character checks, digit values, month and day limits, leap flag
    dvdd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_pair  (front_pair)
    );

    // short queue so front and back stall independently
    dvdd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_pair),
        .o_valid (queue_valid),
        .i_ready (back_ready),
        .o_data  (queue_pair)
    );

    // back: year terms, closed-form day counts, difference and output register
    dvdd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_ready (back_ready),
        .i_pair  (queue_pair),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    // a nonzero difference only comes from two valid dates
    `DVDD_ASSERT_HOLDS(a_diff_needs_both_ok, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[24:2] != 23'd0), m_axis_tdata[0] && m_axis_tdata[1])
    // the unused top bits of a result stay zero
    `DVDD_ASSERT_HOLDS(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[31:25] == 7'd0)
    // an item at the queue head is not dropped while the back stalls
    `DVDD_ASSERT_NEXT(a_queue_keeps_item, i_clk, i_rst_n, queue_valid && !back_ready, queue_valid)
    // a decoded item held in front survives a full queue
    `DVDD_ASSERT_NEXT(a_front_keeps_item, i_clk, i_rst_n, front_valid && !front_ready, front_valid)

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_PAIRS  = 1750;
    localparam int unsigned DRAIN_CYCLES  = 12;
    localparam int unsigned HOLD_AT_PAIR  = 300;
    localparam int unsigned HOLD_CYCLES   = 250;

    // month lengths (february without leap day) and days ahead of each month
    localparam int unsigned MONTH_DAYS [13] =
        '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned DAYS_AHEAD [13] =
        '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    // one result item as the block packs it
    typedef struct packed {
        logic signed [dvdd_pkg::DIFF_W-1:0] day_diff;
        logic                               second_ok;
        logic                               first_ok;
    } t_diff_result;

    // predicts the day difference of each accepted date pair and checks results in order
    class date_pair_board;
        t_diff_result expected_results[$];
        int unsigned  pairs_seen;
        int unsigned  errors;

        // valid flag and day count (01-01-0001 is day 1) of one ten character date
        function automatic bit day_count(input logic [39:0] head, input logic [39:0] tail,
                                         output int unsigned count);
            logic [7:0]  chars [10];
            int unsigned digits [10];
            int unsigned dd, mm, yy, lim, py;
            bit          leap;
            count = 0;
            for (int i = 0; i < 5; i++) begin
                chars[i]     = head[39-8*i -: 8];
                chars[i + 5] = tail[39-8*i -: 8];
            end
            if (chars[2] != dvdd_pkg::DASH_CHAR || chars[5] != dvdd_pkg::DASH_CHAR)
                return 1'b0;
            for (int i = 0; i < 10; i++) begin
                digits[i] = 0;
                if (i != 2 && i != 5) begin
                    if (chars[i] < dvdd_pkg::ZERO_CHAR || chars[i] > dvdd_pkg::NINE_CHAR)
                        return 1'b0;
                    digits[i] = int'(chars[i] - dvdd_pkg::ZERO_CHAR);
                end
            end
            dd = digits[0] * 10 + digits[1];
            mm = digits[3] * 10 + digits[4];
            yy = digits[6] * 1000 + digits[7] * 100 + digits[8] * 10 + digits[9];
            if (mm < 1 || mm > int'(dvdd_pkg::MONTH_DEC)) return 1'b0;
            leap = (yy % 400 == 0) || ((yy % 100 != 0) && (yy % 4 == 0));
            lim = MONTH_DAYS[mm];
            if (mm == int'(dvdd_pkg::MONTH_FEB) && leap) lim = 29;
            if (dd < 1 || dd > lim) return 1'b0;
            if (yy < 1) return 1'b0;
            py = yy - 1;
            count = 365 * py + py / 4 - py / 100 + py / 400 + DAYS_AHEAD[mm]
                  + ((mm > int'(dvdd_pkg::MONTH_FEB) && leap) ? 1 : 0) + dd;
            return 1'b1;
        endfunction

        function void note_pair(input logic [dvdd_pkg::IN_W-1:0] d);
            t_diff_result want;
            int unsigned  c1, c2;
            want.first_ok  = day_count(d[39:0], d[79:40], c1);
            want.second_ok = day_count(d[119:80], d[159:120], c2);
            want.day_diff  = (want.first_ok && want.second_ok) ?
                             dvdd_pkg::DIFF_W'(c2 - c1) : '0;
            expected_results = {expected_results, want};
            pairs_seen++;
        endfunction

        function void check_result(input logic [dvdd_pkg::OUT_W-1:0] d);
            t_diff_result want;
            t_diff_result got;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result item %h", $time, d);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            got  = d[dvdd_pkg::DIFF_W+1:0];
            if (got.first_ok !== want.first_ok) begin
                $display("%0t first_ok: expected %0d actual %0d", $time,
                         want.first_ok, got.first_ok);
                errors++;
            end
            if (got.second_ok !== want.second_ok) begin
                $display("%0t second_ok: expected %0d actual %0d", $time,
                         want.second_ok, got.second_ok);
                errors++;
            end
            if (got.day_diff !== want.day_diff) begin
                $display("%0t day_difference: expected %0d actual %0d", $time,
                         want.day_diff, got.day_diff);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [dvdd_pkg::IN_W-1:0]      s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [dvdd_pkg::OUT_W-1:0]     m_axis_tdata;

    date_pair_board board = new;
    int unsigned    cycle_count = 0;
    bit             sender_burst = 1'b0;

    date_validate_and_day_difference_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // first_head, first_tail, second_head, second_tail
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // first_ok, second_ok, day_difference, zero pad
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // both monitors look at pre-edge values, so they see exactly the handshakes of this edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) board.note_pair(s_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ten characters DD-MM-YYYY, character 0 in the top byte
    function automatic logic [79:0] date_text(input int unsigned dd, input int unsigned mm,
                                              input int unsigned yy);
        return {8'(dvdd_pkg::ZERO_CHAR + dd / 10 % 10), 8'(dvdd_pkg::ZERO_CHAR + dd % 10),
                dvdd_pkg::DASH_CHAR,
                8'(dvdd_pkg::ZERO_CHAR + mm / 10 % 10), 8'(dvdd_pkg::ZERO_CHAR + mm % 10),
                dvdd_pkg::DASH_CHAR,
                8'(dvdd_pkg::ZERO_CHAR + yy / 1000 % 10),
                8'(dvdd_pkg::ZERO_CHAR + yy / 100 % 10),
                8'(dvdd_pkg::ZERO_CHAR + yy / 10 % 10), 8'(dvdd_pkg::ZERO_CHAR + yy % 10)};
    endfunction

    function automatic logic [79:0] put_char(input logic [79:0] text, input int unsigned pos,
                                             input logic [7:0] c);
        logic [79:0] r;
        r = text;
        r[79-8*pos -: 8] = c;
        return r;
    endfunction

    // well formed text, mostly valid, leaning on leap years, month ends and year limits
    function automatic logic [79:0] random_date();
        int unsigned yy, mm, dd, lim;
        case ($urandom_range(0, 9))
            0:       yy = $urandom_range(1, 24) * 400;
            1:       yy = $urandom_range(1, 99) * 100;
            2:       yy = $urandom_range(0, 5);
            3:       yy = $urandom_range(9990, 9999);
            4:       yy = $urandom_range(1, 2499) * 4;
            default: yy = $urandom_range(1, 9999);
        endcase
        mm = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        lim = (mm >= 1 && mm <= 12) ? MONTH_DAYS[mm] : 31;
        if (mm == 2) lim = 29;
        case ($urandom_range(0, 6))
            0:       dd = $urandom_range(lim - 1, lim + 2);
            1:       dd = $urandom_range(0, 99);
            default: dd = $urandom_range(1, lim);
        endcase
        return date_text(dd, mm, yy);
    endfunction

    // broken text: stray bytes, flipped bits, near-miss characters or plain noise
    function automatic logic [79:0] noisy_date();
        logic [79:0] text;
        logic [7:0]  near_miss [4];
        near_miss = '{8'h2F, 8'h3A, dvdd_pkg::DASH_CHAR, 8'hB0};
        text = random_date();
        case ($urandom_range(0, 3))
            0: text = put_char(text, $urandom_range(0, 9), 8'($urandom));
            1: text[$urandom_range(0, 79)] ^= 1'b1;
            2: text = 80'({$urandom, $urandom, $urandom});
            default: text = put_char(text, $urandom_range(0, 9), near_miss[$urandom_range(0, 3)]);
        endcase
        return text;
    endfunction

    // idle gap before an item: mostly none or short, a few long
    function automatic int unsigned idle_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    task automatic send_pair(input logic [79:0] first, input logic [79:0] second);
        int unsigned gap;
        gap = sender_burst ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {second[39:0], second[79:40], first[39:0], first[79:40]};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_directed();
        send_pair(date_text(1, 1, 1), date_text(31, 12, 9999));      // widest positive span
        send_pair(date_text(31, 12, 9999), date_text(1, 1, 1));      // widest negative span
        send_pair(date_text(29, 2, 2000), date_text(29, 2, 1900));   // 400 rule leap, 100 rule not
        send_pair(date_text(28, 2, 2023), date_text(29, 2, 2024));
        send_pair(date_text(28, 2, 2100), date_text(29, 2, 2100));
        send_pair(date_text(0, 1, 2000), date_text(32, 1, 2000));    // day out of range both ways
        send_pair(date_text(31, 4, 2021), date_text(30, 4, 2021));
        send_pair(date_text(15, 0, 2020), date_text(15, 13, 2020));  // month out of range
        send_pair(date_text(1, 1, 0), date_text(1, 1, 1));           // year zero
        send_pair(date_text(1, 3, 2000), date_text(31, 12, 2000));   // leap day counted after feb
        send_pair(date_text(31, 1, 2001), date_text(29, 2, 2004));
        send_pair(date_text(99, 99, 9999), date_text(5, 5, 5));
        send_pair(put_char(date_text(10, 10, 2010), 2, 8'h2F),      // missing dashes
                  put_char(date_text(10, 10, 2010), 5, 8'h2E));
        send_pair(put_char(date_text(10, 10, 2010), 0, 8'h3A),      // just past the digit range
                  put_char(date_text(10, 10, 2010), 9, 8'h2F));
        send_pair(put_char(date_text(10, 10, 2010), 3, 8'hFF),      // non-ascii bytes
                  put_char(date_text(10, 10, 2010), 7, 8'hB0));
        send_pair('0, '1);
        send_pair(date_text(17, 6, 1987), date_text(17, 6, 1987));
    endtask

    // receiver: random stalls, ready stretches, and one long hold-off to back up the block
    initial begin
        int unsigned stall, run, p;
        bit          held;
        held = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && board.pairs_seen >= HOLD_AT_PAIR) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            p = $urandom_range(0, 99);
            if (p < 5) begin
                stall = 0;
                run   = $urandom_range(100, 200);
            end else begin
                stall = idle_len();
                run   = $urandom_range(1, 16);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin
        logic [79:0] first, second;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            // every so often switch between back to back items and random gaps
            if (n % 150 == 0) sender_burst = ($urandom_range(0, 2) == 0);
            first  = ($urandom_range(0, 4) != 0) ? random_date() : noisy_date();
            second = ($urandom_range(0, 4) != 0) ? random_date() : noisy_date();
            if ($urandom_range(0, 19) == 0) second = first;
            send_pair(first, second);
        end
        s_axis_tvalid <= 1'b0;

        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (board.expected_results.size() != 0)
                $display("%0t %0d result items never arrived", $time,
                         board.expected_results.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dvdd_pkg.sv
rtl/dvdd_front.sv
rtl/dvdd_fifo.sv
rtl/dvdd_back.sv
rtl/date_validate_and_day_difference_top.sv
sim/tb_top.sv
